FILE: rtl/frs_pkg.sv
package frs_pkg;

  // quotient bits = dividend bits = divider stages
  localparam int NUM_W      = 16;
  localparam int DEN_W      = 17;
  localparam int DIV_STAGES = NUM_W;

  localparam logic [16:0] HALF_DAY       = 17'd43200;
  localparam logic [15:0] RATE_CAP       = 16'd5000;
  localparam logic [15:0] RATE_CAP_SWEEP = 16'(5000 / 16);

  localparam logic [1:0] CFG_CLOCK_MODE  = 2'd0;
  localparam logic [1:0] CFG_MAX_TICK    = 2'd1;
  localparam logic [1:0] CFG_SYNC_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    MODE_SECOND,
    MODE_MINUTE,
    MODE_SWEEP_SECOND,
    MODE_SWEEP_MINUTE
  } clock_mode_t;

  typedef struct packed {
    clock_mode_t mode;
    logic [6:0]  freq;
    logic [14:0] window;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  net_hours;
    logic [5:0]  net_minutes;
    logic [5:0]  net_seconds;
    logic [15:0] net_rate;
    logic [3:0]  local_hours;
    logic [5:0]  local_minutes;
    logic [5:0]  local_seconds;
    logic [15:0] local_rate;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_rate;
    logic        retime_ticker;
  } out_item_t;

  // decision context, carried alongside the dividers
  typedef struct packed {
    logic [15:0] old_rate;
    logic [15:0] net_rate;
    logic [16:0] m10;
    logic [15:0] cap;
    logic [16:0] cand;     // net_rate + 5d, meaningful when cand_lt
    logic        cand_lt;  // net_rate + 5d < m10
    logic        near;
    logic        eq;
    logic        rate_le;
    logic        rate_ge;
    logic        rate_zero;
    logic        far2;
  } ctx_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_op_t;

endpackage

FILE: rtl/frs_ifs.sv
interface frs_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  net_hours;
  logic [5:0]  net_minutes;
  logic [5:0]  net_seconds;
  logic [15:0] net_rate;
  logic [3:0]  local_hours;
  logic [5:0]  local_minutes;
  logic [5:0]  local_seconds;
  logic [15:0] local_rate;

  modport source (
    output valid, net_hours, net_minutes, net_seconds, net_rate,
           local_hours, local_minutes, local_seconds, local_rate,
    input  ready
  );
  modport sink (
    input  valid, net_hours, net_minutes, net_seconds, net_rate,
           local_hours, local_minutes, local_seconds, local_rate,
    output ready
  );
endinterface

interface frs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] new_rate;
  logic        retime_ticker;

  modport source (output valid, new_rate, retime_ticker, input ready);
  modport sink (input valid, new_rate, retime_ticker, output ready);
endinterface

FILE: rtl/frs_front.sv
module frs_front
  import frs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  cfg_t     cfg,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     ctx_valid,
  output ctx_t     ctx,
  output div_op_t  op_catch,
  output div_op_t  op_wait
);

  // stage A: seconds difference, mode rates
  logic               a_valid_r;
  logic signed [17:0] a_diff_r;
  logic [15:0]        a_rate_r, a_old_r;
  logic [16:0]        a_m10_r, a_lim_r;
  logic [14:0]        a_win_r;
  logic               a_sweep_r;

  logic [15:0]        net_s, loc_s;
  logic signed [17:0] diff_nxt;
  logic [16:0]        f17, m10_nxt, lim_nxt;

  always_comb begin
    net_s = {12'd0, item.net_hours} * 16'd3600 + {10'd0, item.net_minutes} * 16'd60
          + {10'd0, item.net_seconds};
    loc_s = {12'd0, item.local_hours} * 16'd3600 + {10'd0, item.local_minutes} * 16'd60
          + {10'd0, item.local_seconds};
    diff_nxt = $signed({2'b00, net_s}) - $signed({2'b00, loc_s});
    f17 = {10'd0, cfg.freq};
    unique case (cfg.mode)
      MODE_SECOND: begin
        m10_nxt = f17 * 17'd10;
        lim_nxt = f17 * 17'd10;
      end
      MODE_MINUTE: begin
        m10_nxt = f17 * 17'd600;
        lim_nxt = f17 * 17'd600;
      end
      MODE_SWEEP_SECOND: begin
        m10_nxt = (f17 >> 4) * 17'd10;
        lim_nxt = (f17 * 17'd10) >> 4;
      end
      MODE_SWEEP_MINUTE: begin
        m10_nxt = ((f17 * 17'd60) >> 4) * 17'd10;
        lim_nxt = (f17 * 17'd600) >> 4;
      end
    endcase
  end

  // stage B: wrap difference into one half day, rate compares, cap
  logic        b_valid_r;
  logic [15:0] b_d_r, b_rate_r, b_old_r, b_cap_r;
  logic [16:0] b_m10_r;
  logic [14:0] b_win_r;
  logic        b_eq_r, b_le_r, b_ge_r, b_zero_r;

  logic signed [17:0] d_nxt;
  logic [15:0]        cap_nxt;

  always_comb begin
    priority if (a_diff_r >= 18'sd43200) begin
      d_nxt = a_diff_r - 18'sd43200;
    end else if (a_diff_r < -18'sd43200) begin
      d_nxt = a_diff_r + 18'sd86400;
    end else if (a_diff_r < 18'sd0) begin
      d_nxt = a_diff_r + 18'sd43200;
    end else begin
      d_nxt = a_diff_r;
    end
    priority if (a_sweep_r && a_lim_r > {1'b0, RATE_CAP_SWEEP}) begin
      cap_nxt = RATE_CAP_SWEEP;
    end else if (a_lim_r > {1'b0, RATE_CAP}) begin
      cap_nxt = RATE_CAP;
    end else begin
      cap_nxt = a_lim_r[15:0];
    end
  end

  // stage C: window tests, proportional candidate, divider operands
  logic [18:0] s5;
  logic [16:0] d17;

  always_comb begin
    d17 = {1'b0, b_d_r};
    s5  = ({3'b000, b_d_r} << 2) + {3'b000, b_d_r} + {3'b000, b_rate_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      ctx_valid <= 1'b0;
    end else if (en) begin
      a_valid_r <= item_valid;
      b_valid_r <= a_valid_r;
      ctx_valid <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_diff_r  <= diff_nxt;
      a_rate_r  <= item.net_rate;
      a_old_r   <= item.local_rate;
      a_m10_r   <= m10_nxt;
      a_lim_r   <= lim_nxt;
      a_win_r   <= cfg.window;
      a_sweep_r <= (cfg.mode == MODE_SWEEP_SECOND);

      b_d_r    <= d_nxt[15:0];
      b_rate_r <= a_rate_r;
      b_old_r  <= a_old_r;
      b_cap_r  <= cap_nxt;
      b_m10_r  <= a_m10_r;
      b_win_r  <= a_win_r;
      b_eq_r   <= (a_rate_r == a_old_r);
      b_le_r   <= ({1'b0, a_rate_r} <= a_m10_r);
      b_ge_r   <= ({1'b0, a_rate_r} >= a_m10_r);
      b_zero_r <= (a_rate_r == 16'd0);

      ctx.old_rate  <= b_old_r;
      ctx.net_rate  <= b_rate_r;
      ctx.m10       <= b_m10_r;
      ctx.cap       <= b_cap_r;
      ctx.cand      <= s5[16:0];
      ctx.cand_lt   <= (s5 < {2'b00, b_m10_r});
      ctx.near      <= (b_d_r == 16'd0) || (d17 + {2'b00, b_win_r} > HALF_DAY);
      ctx.far2      <= (d17 + {1'b0, b_win_r, 1'b0} > HALF_DAY);
      ctx.eq        <= b_eq_r;
      ctx.rate_le   <= b_le_r;
      ctx.rate_ge   <= b_ge_r;
      ctx.rate_zero <= b_zero_r;

      op_catch.num <= b_d_r;
      op_catch.den <= b_m10_r - {1'b0, b_rate_r};
      op_wait.num  <= 16'(HALF_DAY - d17);
      op_wait.den  <= {1'b0, b_rate_r};
    end
  end

endmodule

FILE: rtl/frs_div.sv
module frs_div
  import frs_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  div_op_t          op,
  output logic [NUM_W-1:0] quo
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] quo;
  } div_st_t;

  // one restoring step: bring down the next dividend bit, trial subtract
  function automatic div_st_t div_step(div_st_t s);
    logic [DEN_W:0] t;
    logic           ge;
    div_st_t        r;
    t     = {s.rem, s.num[NUM_W-1]};
    ge    = (t >= {1'b0, s.den});
    r.rem = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
    r.num = s.num << 1;
    r.den = s.den;
    r.quo = {s.quo[NUM_W-2:0], ge};
    return r;
  endfunction

  div_st_t st_in;
  div_st_t st_r [DIV_STAGES];

  always_comb begin
    st_in.rem = '0;
    st_in.num = op.num;
    st_in.den = op.den;
    st_in.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(st_in);
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].quo;

endmodule

FILE: rtl/frs_back.sv
module frs_back
  import frs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             ctx_valid,
  input  ctx_t             ctx,
  input  logic [NUM_W-1:0] quo_catch,
  input  logic [NUM_W-1:0] quo_wait,
  output logic             res_valid,
  output out_item_t        res
);

  logic        v_r;
  logic [16:0] rate_r, rate_nxt;
  logic        chg_r;
  logic [15:0] cap_r;

  always_comb begin
    priority if (ctx.near && ctx.eq) begin
      rate_nxt = {1'b0, ctx.old_rate};
    end else if (ctx.near && ctx.rate_le) begin
      rate_nxt = {1'b0, ctx.net_rate};
    end else if (ctx.rate_zero) begin
      rate_nxt = ctx.far2 ? 17'd0 : ctx.m10;
    end else if (ctx.rate_ge) begin
      rate_nxt = 17'd0;
    end else if (quo_wait <= quo_catch) begin
      rate_nxt = 17'd0;
    end else if (ctx.cand_lt) begin
      rate_nxt = ctx.cand;
    end else begin
      rate_nxt = ctx.m10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= ctx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rate_r <= rate_nxt;
      chg_r  <= (rate_nxt != {1'b0, ctx.old_rate});
      cap_r  <= ctx.cap;
    end
  end

  // limits apply only to a changed rate; an unchanged one is the 16-bit old rate
  always_comb begin
    res_valid         = v_r;
    res.retime_ticker = chg_r;
    if (chg_r && rate_r > {1'b0, cap_r}) begin
      res.new_rate = cap_r;
    end else begin
      res.new_rate = rate_r[15:0];
    end
  end

endmodule

FILE: rtl/fastclock_rate_sync.sv
// Each item passes the front stages, the divider stages and the decision stage into the output register.
// Throughput: one item per cycle while the skid entry is empty; 3 front stages, 16 divider stages, 1 decision stage.
// The output register plus a one-entry skid buffer let the pipeline run while a
//   result waits; the pipeline freezes only while the skid entry is occupied.
// Reset (rst_n low, synchronous) empties the pipeline and sets clock_mode 0,
//   max_tick_frequency 1, sync_window_seconds 30.
module fastclock_rate_sync
  import frs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  frs_in_if.sink      in_ch,
  frs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_SECOND;
      cfg_r.freq   <= 7'd1;
      cfg_r.window <= 15'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOCK_MODE:  cfg_r.mode   <= clock_mode_t'(cfg_data[1:0]);
        CFG_MAX_TICK:    cfg_r.freq   <= cfg_data[6:0];
        CFG_SYNC_WINDOW: cfg_r.window <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline advance: every stage moves unless the skid entry is full.
  // en is a register output, so ready has no path from out_ch.ready.
  // ---------------------------------------------------------------
  logic      skid_valid_r;
  out_item_t skid_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      en;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  in_item_t item;

  always_comb begin
    item.net_hours     = in_ch.net_hours;
    item.net_minutes   = in_ch.net_minutes;
    item.net_seconds   = in_ch.net_seconds;
    item.net_rate      = in_ch.net_rate;
    item.local_hours   = in_ch.local_hours;
    item.local_minutes = in_ch.local_minutes;
    item.local_seconds = in_ch.local_seconds;
    item.local_rate    = in_ch.local_rate;
  end

  // ---------------------------------------------------------------
  // Front: time difference, mode rates, compares, divider operands
  // ---------------------------------------------------------------
  logic    front_valid;
  ctx_t    front_ctx;
  div_op_t op_catch, op_wait;

  frs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .item_valid (in_ch.valid),
    .item       (item),
    .ctx_valid  (front_valid),
    .ctx        (front_ctx),
    .op_catch   (op_catch),
    .op_wait    (op_wait)
  );

  // ---------------------------------------------------------------
  // Two pipelined dividers: catch-up time d / (10M - R) and
  // waiting time (43200 - d) / R, one quotient bit per stage.
  // ---------------------------------------------------------------
  logic [NUM_W-1:0] quo_catch, quo_wait;

  frs_div u_div_catch (
    .clk (clk),
    .en  (en),
    .op  (op_catch),
    .quo (quo_catch)
  );

  frs_div u_div_wait (
    .clk (clk),
    .en  (en),
    .op  (op_wait),
    .quo (quo_wait)
  );

  // context and valid bits travel in step with the divider stages
  logic ctx_v_r [DIV_STAGES];
  ctx_t ctx_d_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        ctx_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      ctx_v_r[0] <= front_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        ctx_v_r[k] <= ctx_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_d_r[0] <= front_ctx;
      for (int k = 1; k < DIV_STAGES; k++) begin
        ctx_d_r[k] <= ctx_d_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Decision among the five rules, then mode / absolute limits
  // ---------------------------------------------------------------
  logic      res_valid;
  out_item_t res;

  frs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctx_valid (ctx_v_r[DIV_STAGES-1]),
    .ctx       (ctx_d_r[DIV_STAGES-1]),
    .quo_catch (quo_catch),
    .quo_wait  (quo_wait),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---------------------------------------------------------------
  // Output register with skid entry. A result leaving the pipeline
  // while the output waits goes to the skid entry; the skid drains
  // into the output on the next transfer.
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (out_ch.ready) begin
          out_valid_r  <= 1'b1;
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= res_valid;
        out_data_r  <= res;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_rate      = out_data_r.new_rate;
  assign out_ch.retime_ticker = out_data_r.retime_ticker;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry lost or changed while output stalled");

  a_frozen_result: assert property (@(posedge clk) disable iff (!rst_n)
    !en && res_valid |=> res_valid && $stable(res))
    else $error("pipeline result moved during stall");

  a_retime_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.retime_ticker |-> out_data_r.new_rate <= RATE_CAP)
    else $error("changed rate above absolute cap");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("output not empty after reset");

endmodule
